// File: rtl/nlc_pkg.sv
// Shared types, constants and per-byte update function for the NMEA line checker.
// No dependencies.
`default_nettype none

package nlc_pkg;

	localparam int MAX_LINE   = 256;
	localparam int MAX_FIELDS = 32;

	localparam int LEN_W   = $clog2(MAX_LINE + 2);
	localparam int FIELD_W = 6;
	localparam int KIND_N  = 6;

	localparam logic [LEN_W-1:0]   LEN_SAT   = LEN_W'(MAX_LINE + 1);
	localparam logic [LEN_W-1:0]   LEN_LIMIT = LEN_W'(MAX_LINE);
	localparam logic [FIELD_W-1:0] FIELD_SAT = '1;
	localparam logic [FIELD_W-1:0] FIELD_CAP = FIELD_W'(MAX_FIELDS);

	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;

	// line phase codes
	localparam logic [1:0] PH_WAIT = 2'd0;
	localparam logic [1:0] PH_SUM  = 2'd1;
	localparam logic [1:0] PH_TAIL = 2'd2;

	localparam logic [1:0] TAIL_NONE = 2'd0;
	localparam logic [1:0] TAIL_ONE  = 2'd1;
	localparam logic [1:0] TAIL_TWO  = 2'd2;

	// sentence patterns in priority order; kind code is index + 1
	localparam logic [23:0] KIND_PAT [KIND_N] = '{
		24'h474741,  // GGA
		24'h475341,  // GSA
		24'h475356,  // GSV
		24'h524D43,  // RMC
		24'h474C4C,  // GLL
		24'h565447   // VTG
	};

	typedef struct packed {
		logic [1:0]        phase;
		logic [7:0]        sum;
		logic [1:0]        tail_cnt;
		logic [7:0]        recv;
		logic [1:0]        digit_ok;
		logic [LEN_W-1:0]  line_len;
		logic              ovf;
		logic              star;
		logic [FIELD_W-1:0] fields;
		logic              in_field;
		logic [15:0]       recent;
		logic [KIND_N-1:0] hits;
	} line_state_t;

	// {valid, value}
	function automatic logic [4:0] hex_digit(logic [7:0] b);
		logic [4:0] r;
		r = '0;
		if (b >= 8'h30 && b <= 8'h39) r = {1'b1, 4'(b - 8'h30)};
		else if (b >= 8'h61 && b <= 8'h66) r = {1'b1, 4'(b - 8'h57)};
		else if (b >= 8'h41 && b <= 8'h46) r = {1'b1, 4'(b - 8'h37)};
		return r;
	endfunction

	function automatic line_state_t take_byte(line_state_t s, logic [7:0] b);
		line_state_t n;
		logic [4:0]  h;
		n = s;
		h = hex_digit(b);

		if (s.line_len < LEN_SAT) n.line_len = s.line_len + 1'b1;
		if (n.line_len > LEN_LIMIT) n.ovf = 1'b1;

		case (s.phase)
			PH_WAIT: begin
				if (b == CH_DOLLAR) begin
					n.phase = PH_SUM;
					n.sum   = '0;
				end
			end
			PH_SUM: begin
				if (b == CH_STAR) n.phase = PH_TAIL;
				else n.sum = s.sum ^ b;
			end
			default: begin
				if (s.tail_cnt == TAIL_NONE) begin
					n.recv     = h[4] ? {4'h0, h[3:0]} : 8'h00;
					n.digit_ok = {1'b0, h[4]};
					n.tail_cnt = TAIL_ONE;
				end else if (s.tail_cnt == TAIL_ONE) begin
					if (s.digit_ok[0] && h[4]) begin
						n.recv        = {s.recv[3:0], h[3:0]};
						n.digit_ok[1] = 1'b1;
					end
					n.tail_cnt = TAIL_TWO;
				end
			end
		endcase

		if (!s.star) begin
			if (b == CH_STAR) begin
				n.star     = 1'b1;
				n.in_field = 1'b0;
			end else if (b == CH_COMMA) begin
				n.in_field = 1'b0;
			end else begin
				if (!s.in_field) begin
					n.in_field = 1'b1;
					if (s.fields < FIELD_SAT) n.fields = s.fields + 1'b1;
					n.recent = '0;
				end
				if (n.fields == FIELD_W'(1)) begin
					for (int i = 0; i < KIND_N; i++) begin
						if (n.recent == KIND_PAT[i][23:8] && b == KIND_PAT[i][7:0])
							n.hits[i] = 1'b1;
					end
				end
				n.recent = {n.recent[7:0], b};
			end
		end
		return n;
	endfunction

endpackage

`default_nettype wire

// File: rtl/nlc_if.sv
// Handshake channels of the NMEA line checker: byte input and line result.
// Depends on nothing.
`default_nettype none

interface nlc_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface nlc_res_if;
	logic       valid;
	logic       ready;
	logic       checksum_ok;
	logic [2:0] sentence_kind;
	logic [5:0] field_count;
	logic [7:0] computed_checksum;
	logic       line_overflow;

	modport source (output valid, output checksum_ok, output sentence_kind,
		output field_count, output computed_checksum, output line_overflow,
		input ready);
	modport sink (input valid, input checksum_ok, input sentence_kind,
		input field_count, input computed_checksum, input line_overflow,
		output ready);
endinterface

`default_nettype wire

// File: rtl/nmea_line_checker_core.sv
// NMEA line checker: one byte per cycle in, one result per newline out.
// A newline is registered in the byte stage at accept; its result is then registered on advance.
// Throughput: one byte per cycle; a newline stalls only while the result register
// is full and not taken. A held carriage return and the next byte update the state together.
// Reset (arst_n low, asynchronous) clears the line state and both valid flags.
// Depends on nlc_pkg and the channels in nlc_if.sv.
`default_nettype none

module nmea_line_checker_core
	import nlc_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	nlc_byte_if.sink   rx,
	nlc_res_if.source  line_res
);

	logic        byte_v_s1;
	logic [7:0]  byte_s1;
	logic        advance;
	logic        is_lf;

	line_state_t st_q, st_d, st_pre;
	logic        pend_q, pend_d;

	logic        res_v_q;
	logic        ok_q, ovf_q;
	logic [2:0]  kind_q, kind_d;
	logic [5:0]  cnt_q, cnt_d;
	logic [7:0]  sum_q, sum_d;
	logic        ok_d;

	assign is_lf   = (byte_s1 == CH_LF);
	assign advance = !is_lf || !res_v_q || line_res.ready;
	assign rx.ready = !byte_v_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_v_s1 <= 1'b0;
		end else if (rx.valid && rx.ready) begin
			byte_v_s1 <= 1'b1;
		end else if (advance) begin
			byte_v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) byte_s1 <= rx.rx_byte;
	end

	// next line state; a held CR is taken ahead of the current byte
	always_comb begin
		st_pre = pend_q ? take_byte(st_q, CH_CR) : st_q;
		st_d   = st_q;
		pend_d = pend_q;
		if (is_lf) begin
			st_d   = '0;
			pend_d = 1'b0;
		end else if (byte_s1 == CH_CR) begin
			st_d   = st_pre;
			pend_d = 1'b1;
		end else begin
			st_d   = take_byte(st_pre, byte_s1);
			pend_d = 1'b0;
		end
	end

	always_comb begin
		kind_d = '0;
		for (int i = KIND_N - 1; i >= 0; i--) begin
			if (st_q.hits[i]) kind_d = 3'(i + 1);
		end
		cnt_d = (st_q.fields > FIELD_CAP) ? FIELD_CAP : st_q.fields;
		sum_d = (st_q.phase != PH_WAIT) ? st_q.sum : 8'h00;
		ok_d  = (st_q.phase == PH_TAIL) && (st_q.tail_cnt == TAIL_TWO) &&
			(st_q.sum == st_q.recv);
		if (st_q.ovf) begin
			kind_d = '0;
			cnt_d  = '0;
			sum_d  = '0;
			ok_d   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= '0;
			pend_q  <= 1'b0;
			res_v_q <= 1'b0;
		end else begin
			if (byte_v_s1 && advance) begin
				st_q   <= st_d;
				pend_q <= pend_d;
			end
			if (byte_v_s1 && advance && is_lf) res_v_q <= 1'b1;
			else if (line_res.ready) res_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_v_s1 && advance && is_lf) begin
			ok_q   <= ok_d;
			kind_q <= kind_d;
			cnt_q  <= cnt_d;
			sum_q  <= sum_d;
			ovf_q  <= st_q.ovf;
		end
	end

	assign line_res.valid             = res_v_q;
	assign line_res.checksum_ok       = ok_q;
	assign line_res.sentence_kind     = kind_q;
	assign line_res.field_count       = cnt_q;
	assign line_res.computed_checksum = sum_q;
	assign line_res.line_overflow     = ovf_q;

endmodule

`default_nettype wire

// File: bench/nmea_line_checker_core_test.sv
// Testbench for nmea_line_checker_core: drives NMEA byte streams, predicts one verdict per line.
// Uses nlc_pkg constants, the nlc_byte_if / nlc_res_if channels and the core under test.
// Directed line cases first, then a random stream of sentences, noise and long lines.
`default_nettype none

module nmea_line_checker_core_test
	import nlc_pkg::*;
();

	localparam int QUIET_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 10;
	localparam int RANDOM_BYTES = 600;
	localparam int RANDOM_LINES = 12;
	localparam int FIELD_LIMIT  = 63;
	localparam int TAG_COUNT    = 6;

	localparam logic [2:0] KIND_NONE = 3'd0;
	// tag index i reports kind i + 1; lower index wins
	localparam logic [23:0] SENTENCE_TAGS [TAG_COUNT] = '{"GGA", "GSA", "GSV", "RMC", "GLL", "VTG"};

	typedef struct packed {
		logic       ok;
		logic [2:0] kind;
		logic [5:0] fields;
		logic [7:0] sum;
		logic       overflow;
	} line_verdict_t;

	logic clk = 1'b0;
	logic arst_n;

	nlc_byte_if byte_ch ();
	nlc_res_if  res_ch ();

	nmea_line_checker_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx       (byte_ch),
		.line_res (res_ch)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	line_verdict_t awaited_verdicts [$];
	logic [7:0]    line_buf [$];
	int            mismatch_count = 0;
	int            burst_left = 0;
	int            bytes_sent = 0;
	int            lines_sent = 0;
	int            quiet_cycles = 0;
	int            stall_tick = 0;
	int            stall_mode = 0;

	// line tracker state
	logic [1:0] ph;
	logic [7:0] xor_acc;
	int         tail_seen;
	logic [7:0] rx_sum;
	bit         first_hex;
	bit         cr_held;
	int         line_len;
	bit         too_long;
	bit         star_hit;
	int         nfields;
	bit         in_fld;
	logic [7:0] prev2, prev1;
	logic [TAG_COUNT-1:0] tag_hits;

	function automatic void clear_line_state();
		ph = PH_WAIT;
		xor_acc = '0;
		tail_seen = 0;
		rx_sum = '0;
		first_hex = 0;
		cr_held = 0;
		line_len = 0;
		too_long = 0;
		star_hit = 0;
		nfields = 0;
		in_fld = 0;
		prev2 = '0;
		prev1 = '0;
		tag_hits = '0;
	endfunction

	function automatic bit hex_nibble(input logic [7:0] c, output logic [3:0] v);
		v = '0;
		if (c >= "0" && c <= "9") v = 4'(c - "0");
		else if (c >= "a" && c <= "f") v = 4'(c - "a" + 10);
		else if (c >= "A" && c <= "F") v = 4'(c - "A" + 10);
		else return 0;
		return 1;
	endfunction

	function automatic void fold_byte(input logic [7:0] c);
		logic [3:0] v;
		bit         is_hex;
		is_hex = hex_nibble(c, v);
		if (line_len < MAX_LINE + 1) line_len++;
		if (line_len > MAX_LINE) too_long = 1;
		case (ph)
			PH_WAIT: begin
				if (c == CH_DOLLAR) begin
					ph = PH_SUM;
					xor_acc = '0;
				end
			end
			PH_SUM: begin
				if (c == CH_STAR) ph = PH_TAIL;
				else xor_acc ^= c;
			end
			default: begin
				if (tail_seen == 0) begin
					rx_sum = is_hex ? {4'h0, v} : 8'h00;
					first_hex = is_hex;
					tail_seen = 1;
				end else if (tail_seen == 1) begin
					if (first_hex && is_hex) rx_sum = {rx_sum[3:0], v};
					tail_seen = 2;
				end
			end
		endcase
		// field scan stops at the first star of the line
		if (!star_hit) begin
			if (c == CH_STAR) begin
				star_hit = 1;
				in_fld = 0;
			end else if (c == CH_COMMA) begin
				in_fld = 0;
			end else begin
				if (!in_fld) begin
					in_fld = 1;
					if (nfields < FIELD_LIMIT) nfields++;
					prev2 = '0;
					prev1 = '0;
				end
				if (nfields == 1)
					for (int i = 0; i < TAG_COUNT; i++)
						if ({prev2, prev1, c} == SENTENCE_TAGS[i]) tag_hits[i] = 1'b1;
				prev2 = prev1;
				prev1 = c;
			end
		end
	endfunction

	function automatic void predict_char(input logic [7:0] c);
		line_verdict_t v;
		if (c != CH_LF) begin
			// a CR is held back until we know it is not the one before LF
			if (cr_held) begin
				cr_held = 0;
				fold_byte(CH_CR);
			end
			if (c == CH_CR) cr_held = 1;
			else fold_byte(c);
			return;
		end
		v = '0;
		if (too_long) begin
			v.overflow = 1'b1;
		end else begin
			v.ok = (ph == PH_TAIL && tail_seen == 2 && xor_acc == rx_sum);
			v.kind = KIND_NONE;
			for (int i = TAG_COUNT - 1; i >= 0; i--)
				if (tag_hits[i]) v.kind = 3'(i + 1);
			v.fields = (nfields > MAX_FIELDS) ? 6'(MAX_FIELDS) : 6'(nfields);
			v.sum = (ph != PH_WAIT) ? xor_acc : 8'h00;
		end
		awaited_verdicts.push_back(v);
		clear_line_state();
	endfunction

	function automatic void check_field(input string what, input int want, input int got);
		if (want != got) begin
			mismatch_count++;
			$display("%0t: %s expected %0d actual %0d", $time, what, want, got);
		end
	endfunction

	always @(posedge clk) begin : result_check
		line_verdict_t want;
		if (res_ch.valid && res_ch.ready) begin
			if (awaited_verdicts.size() == 0) begin
				mismatch_count++;
				$display("%0t: result with no line pending", $time);
			end else begin
				want = awaited_verdicts.pop_front();
				check_field("checksum_ok", want.ok, res_ch.checksum_ok);
				check_field("sentence_kind", want.kind, res_ch.sentence_kind);
				check_field("field_count", want.fields, res_ch.field_count);
				check_field("computed_checksum", want.sum, res_ch.computed_checksum);
				check_field("line_overflow", want.overflow, res_ch.line_overflow);
			end
		end
	end

	// receiver stall pattern, mode re-drawn at random from four patterns
	always @(negedge clk) begin
		stall_tick++;
		if (stall_tick % 64 == 0) stall_mode = $urandom_range(0, 3);
		case (stall_mode)
			0: res_ch.ready = 1'b1;
			1: res_ch.ready = stall_tick[0];
			2: res_ch.ready = (stall_tick % 8) < 5;
			default: res_ch.ready = ($urandom_range(0, 3) != 0);
		endcase
	end

	always @(posedge clk) begin
		if ((byte_ch.valid && byte_ch.ready) || (res_ch.valid && res_ch.ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	// called just after a falling edge; returns just after a later one, once the byte is taken
	task automatic send_byte(input logic [7:0] c);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				byte_ch.valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 150)
				: $urandom_range(1, 20);
		end
		byte_ch.valid = 1'b1;
		byte_ch.rx_byte = c;
		@(posedge clk);
		while (!byte_ch.ready) @(posedge clk);
		predict_char(c);
		bytes_sent++;
		burst_left--;
		@(negedge clk);
	endtask

	function automatic void buf_text(input string s);
		for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
		if (n < 10) return 8'("0" + n);
		return lower ? 8'("a" + n - 10) : 8'("A" + n - 10);
	endfunction

	// appends '*' and two hex digits of the XOR after the first '$', flipped by flip
	function automatic void buf_checksum(input logic [7:0] flip, input bit lower);
		logic [7:0] x;
		bit         started;
		x = '0;
		started = 0;
		foreach (line_buf[i]) begin
			if (started) x ^= line_buf[i];
			else if (line_buf[i] == CH_DOLLAR) started = 1;
		end
		x ^= flip;
		line_buf.push_back(CH_STAR);
		line_buf.push_back(hex_char(x[7:4], lower));
		line_buf.push_back(hex_char(x[3:0], lower));
	endfunction

	task automatic send_buf(input bit with_cr);
		foreach (line_buf[i]) send_byte(line_buf[i]);
		if (with_cr) send_byte(CH_CR);
		send_byte(CH_LF);
		line_buf.delete();
		lines_sent++;
	endtask

	task automatic sentence(input string body, input logic [7:0] flip, input bit lower,
			input bit with_cr);
		buf_text("$");
		buf_text(body);
		buf_checksum(flip, lower);
		send_buf(with_cr);
	endtask

	task automatic test_framing();
		sentence("GPGGA,123519,4807.038,N", 8'h00, 0, 1);
		sentence("GPRMC,1,2", 8'h5A, 0, 1);
		buf_text("GPGGA,1*00");
		send_buf(1);
		buf_text("$GPGLL,1,2");
		send_buf(0);
		buf_text("$GPVTG*4");
		send_buf(0);
		send_buf(0);
	endtask

	task automatic test_hex_tail();
		sentence("GPGSA,A,3", 8'h00, 1, 0);
		sentence("GPGSV,2,1,08", 8'h00, 0, 0);
		// first tail byte not hex: received value is zero
		buf_text("$AA* 1");
		send_buf(1);
		buf_text("$AA*-5");
		send_buf(0);
		buf_text("$AA*+0");
		send_buf(0);
		// only the second is not hex: value is the first digit
		buf_text("$01*1G");
		send_buf(0);
		buf_text("$01*1 ");
		send_buf(1);
	endtask

	task automatic test_line_ends();
		buf_text("$GP");
		line_buf.push_back(CH_CR);
		buf_text("GSV,1");
		buf_checksum(8'h00, 0);
		send_buf(1);
		// two CRs before LF: the first is an ordinary tail byte
		buf_text("$GPGLL,5");
		buf_checksum(8'h00, 0);
		line_buf.push_back(CH_CR);
		send_buf(1);
		buf_text("$GP");
		line_buf.push_back(8'h00);
		buf_text("RMC,1");
		buf_checksum(8'h00, 1);
		send_buf(1);
		send_buf(1);
	endtask

	task automatic test_sentence_kinds();
		for (int i = 0; i < TAG_COUNT; i++) begin
			buf_text("$GN");
			line_buf.push_back(SENTENCE_TAGS[i][23:16]);
			line_buf.push_back(SENTENCE_TAGS[i][15:8]);
			line_buf.push_back(SENTENCE_TAGS[i][7:0]);
			buf_text(",1,,2");
			buf_checksum(8'h00, 0);
			send_buf(1);
		end
		sentence("XXGSVGGA,7", 8'h00, 0, 1);
		sentence(",,GPRMC,1", 8'h00, 0, 1);
		sentence("GPXYZ,GGA", 8'h00, 0, 1);
		buf_text("$A*41GGA,B");
		send_buf(1);
		buf_text("xx$GPGGA,1");
		buf_checksum(8'h00, 0);
		send_buf(0);
	endtask

	task automatic test_long_lines();
		// 256 bytes: at the limit; 257: one past it
		for (int n = 253; n <= 254; n++) begin
			buf_text("$GPGGA");
			while (line_buf.size() < n)
				line_buf.push_back((line_buf.size() % 3 == 0) ? CH_COMMA : 8'("7"));
			buf_checksum(8'h00, 0);
			send_buf(n == 253);
		end
		repeat (300) line_buf.push_back(8'($urandom_range(32, 126)));
		send_buf(1);
	endtask

	function automatic logic [7:0] field_char();
		case ($urandom_range(0, 19))
			0: return 8'($urandom_range(0, 255));
			1, 2: return 8'(".");
			3, 4, 5, 6: return 8'($urandom_range("A", "Z"));
			7, 8: return 8'($urandom_range("a", "z"));
			default: return 8'($urandom_range("0", "9"));
		endcase
	endfunction

	task automatic random_line();
		int roll, nf, tag;
		roll = $urandom_range(0, 99);
		if (roll < 12) begin
			repeat ($urandom_range(0, 24)) line_buf.push_back(8'($urandom_range(0, 255)));
			send_buf(1'($urandom_range(0, 1)));
			return;
		end
		if (roll < 15) begin
			repeat ($urandom_range(250, 300)) line_buf.push_back(8'($urandom_range(32, 126)));
			send_buf(1'($urandom_range(0, 1)));
			return;
		end
		if ($urandom_range(0, 19) == 0)
			repeat ($urandom_range(1, 4)) line_buf.push_back(8'($urandom_range(32, 126)));
		line_buf.push_back(CH_DOLLAR);
		if ($urandom_range(0, 9) == 0) line_buf.push_back(CH_COMMA);
		if ($urandom_range(0, 1) == 0) begin
			buf_text("GP");
		end else begin
			line_buf.push_back(8'($urandom_range("A", "Z")));
			line_buf.push_back(8'($urandom_range("A", "Z")));
		end
		if ($urandom_range(0, 4) != 0) begin
			tag = $urandom_range(0, TAG_COUNT - 1);
			line_buf.push_back(SENTENCE_TAGS[tag][23:16]);
			line_buf.push_back(SENTENCE_TAGS[tag][15:8]);
			line_buf.push_back(SENTENCE_TAGS[tag][7:0]);
		end else begin
			repeat (3) line_buf.push_back(8'($urandom_range("A", "Z")));
		end
		nf = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 45) : $urandom_range(0, 10);
		repeat (nf) begin
			line_buf.push_back(CH_COMMA);
			if ($urandom_range(0, 4) != 0)
				repeat ($urandom_range(1, 6)) line_buf.push_back(field_char());
		end
		case ($urandom_range(0, 19))
			0: ;
			1: begin
				line_buf.push_back(CH_STAR);
				line_buf.push_back(8'($urandom_range(32, 126)));
			end
			2: begin
				line_buf.push_back(CH_STAR);
				repeat (2) line_buf.push_back(8'($urandom_range(32, 126)));
			end
			default: buf_checksum(($urandom_range(0, 4) == 0) ? 8'($urandom_range(1, 255)) : 8'h00,
				1'($urandom_range(0, 1)));
		endcase
		send_buf($urandom_range(0, 9) != 0);
	endtask

	task automatic test_random_stream();
		int start_bytes, start_lines;
		start_bytes = bytes_sent;
		start_lines = lines_sent;
		while (bytes_sent - start_bytes < RANDOM_BYTES || lines_sent - start_lines < RANDOM_LINES)
			random_line();
	endtask

	initial begin
		arst_n = 1'b0;
		byte_ch.valid = 1'b0;
		byte_ch.rx_byte = 8'h00;
		clear_line_state();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_framing();
		test_hex_tail();
		test_line_ends();
		test_sentence_kinds();
		test_long_lines();
		test_random_stream();

		byte_ch.valid = 1'b0;
		while (awaited_verdicts.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0) $display("Verification passed");
		else $display("Verification failed");
		$finish;
	end

endmodule

`default_nettype wire
